### design/rdi_pkg.sv
package rdi_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_CENTER_X     = 3'd0;
   localparam logic [2:0] CSR_CENTER_Y     = 3'd1;
   localparam logic [2:0] CSR_CENTER_Z     = 3'd2;
   localparam logic [2:0] CSR_NORMAL_X     = 3'd3;
   localparam logic [2:0] CSR_NORMAL_Y     = 3'd4;
   localparam logic [2:0] CSR_NORMAL_Z     = 3'd5;
   localparam logic [2:0] CSR_RADIUS       = 3'd6;
   localparam logic [2:0] CSR_CASTS_SHADOW = 3'd7;

   // test kinds
   localparam logic OP_PRIMARY = 1'b0;
   localparam logic OP_SHADOW  = 1'b1;

   // magnitude widths of the plane numerator and denominator
   localparam int NUM_W = 51;
   localparam int DEN_W = 50;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic [30:0]        radius;
      logic               casts_shadow;
   } cfg_type;

   // ray data that rides along the pipeline
   typedef struct packed {
      logic             miss;
      logic             opcode;
      logic [2:0][31:0] origin;
      logic [2:0][31:0] direction;
   } ray_meta_type;

   typedef struct packed {
      logic               valid;
      ray_meta_type       meta;
      logic               neg;
      logic [NUM_W-1:0]   num_mag;
      logic [DEN_W-1:0]   den_mag;
   } div_in_type;

   typedef struct packed {
      logic               valid;
      ray_meta_type       meta;
      logic signed [31:0] t;
   } div_out_type;

endpackage

### design/rdi_front.sv
module rdi_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  rdi_pkg::cfg_type    cfg,
   input  logic                in_valid,
   input  logic                in_opcode,
   input  logic [2:0][31:0]    in_origin,
   input  logic [2:0][31:0]    in_direction,
   output rdi_pkg::div_in_type out
);

   localparam longint PAR_LIM = ((64'd1 << (14 + FRAC_BITS)) + 64'd999) / 64'd1000;

   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   rdi_pkg::ray_meta_type m1_ff, m2_ff, m3_ff, m4_ff;
   logic signed [32:0]    co_ff [3];
   logic signed [47:0]    pd_ff [3];
   logic signed [48:0]    pn_ff [3];
   logic signed [rdi_pkg::DEN_W-1:0] den_ff;
   logic signed [rdi_pkg::NUM_W-1:0] num_ff;
   logic                  neg_ff;
   logic [rdi_pkg::NUM_W-1:0] a_ff;
   logic [rdi_pkg::DEN_W-1:0] b_ff;
   logic signed [15:0]    nrm [3];
   logic signed [31:0]    ctr [3];
   logic [rdi_pkg::DEN_W-1:0] b_in;

   assign nrm[0] = cfg.normal_x;
   assign nrm[1] = cfg.normal_y;
   assign nrm[2] = cfg.normal_z;
   assign ctr[0] = cfg.center_x;
   assign ctr[1] = cfg.center_y;
   assign ctr[2] = cfg.center_z;

   assign b_in = den_ff[rdi_pkg::DEN_W-1] ? rdi_pkg::DEN_W'(-den_ff) : den_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // payload stages: offset, products, sums, magnitudes
   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff.miss      <= (in_opcode == rdi_pkg::OP_SHADOW) && !cfg.casts_shadow;
         m1_ff.opcode    <= in_opcode;
         m1_ff.origin    <= in_origin;
         m1_ff.direction <= in_direction;
         for (int i = 0; i < 3; i++) begin
            co_ff[i] <= 33'(ctr[i]) - 33'($signed(in_origin[i]));
         end
         m2_ff <= m1_ff;
         for (int i = 0; i < 3; i++) begin
            pn_ff[i] <= 49'(co_ff[i]) * 49'(nrm[i]);
            pd_ff[i] <= 48'($signed(m1_ff.direction[i])) * 48'(nrm[i]);
         end
         m3_ff  <= m2_ff;
         num_ff <= rdi_pkg::NUM_W'(pn_ff[0]) + rdi_pkg::NUM_W'(pn_ff[1])
                   + rdi_pkg::NUM_W'(pn_ff[2]);
         den_ff <= rdi_pkg::DEN_W'(pd_ff[0]) + rdi_pkg::DEN_W'(pd_ff[1])
                   + rdi_pkg::DEN_W'(pd_ff[2]);
         m4_ff.opcode    <= m3_ff.opcode;
         m4_ff.origin    <= m3_ff.origin;
         m4_ff.direction <= m3_ff.direction;
         m4_ff.miss      <= m3_ff.miss || (b_in < rdi_pkg::DEN_W'(PAR_LIM));
         neg_ff     <= num_ff[rdi_pkg::NUM_W-1] != den_ff[rdi_pkg::DEN_W-1];
         a_ff       <= num_ff[rdi_pkg::NUM_W-1] ? rdi_pkg::NUM_W'(-num_ff) : num_ff;
         b_ff       <= b_in;
      end
   end

   assign out.valid   = v4_ff;
   assign out.meta    = m4_ff;
   assign out.neg     = neg_ff;
   assign out.num_mag = a_ff;
   assign out.den_mag = b_ff;

endmodule

### design/rdi_divider.sv
module rdi_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  rdi_pkg::div_in_type  in,
   output rdi_pkg::div_out_type out
);

   localparam int STEPS = 32;
   localparam int REM_W = rdi_pkg::DEN_W + 1;

   logic                  valid_ff [STEPS+1];
   rdi_pkg::ray_meta_type meta_ff  [STEPS+1];
   logic                  neg_ff   [STEPS+1];
   logic                  ovf_ff   [STEPS+1];
   logic [rdi_pkg::DEN_W-1:0] b_ff [STEPS+1];
   logic [REM_W-1:0]      rem_ff   [STEPS+1];
   logic [31:0]           q_ff     [STEPS+1];
   logic [31:0]           low_ff   [STEPS+1];
   logic [REM_W-1:0]      rem_in   [STEPS+1];
   logic                  qbit_in  [STEPS+1];
   logic [REM_W-1:0]      rem0;
   logic                  out_valid_ff;
   rdi_pkg::ray_meta_type out_meta_ff;
   logic signed [31:0]    t_ff;

   assign rem0 = REM_W'(in.num_mag >> (32 - FRAC_BITS));

   // one restoring step per stage
   always_comb begin
      rem_in[0]  = '0;
      qbit_in[0] = 1'b0;
      for (int k = 1; k <= STEPS; k++) begin
         logic [REM_W-1:0] sh;
         sh = {rem_ff[k-1][REM_W-2:0], low_ff[k-1][31]};
         qbit_in[k] = sh >= REM_W'(b_ff[k-1]);
         rem_in[k]  = qbit_in[k] ? sh - REM_W'(b_ff[k-1]) : sh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STEPS; k++) begin
            valid_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in.valid;
         for (int k = 1; k <= STEPS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         out_valid_ff <= valid_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // setup: overflow check and leading remainder
         meta_ff[0] <= in.meta;
         neg_ff[0]  <= in.neg;
         ovf_ff[0]  <= rem0 >= REM_W'(in.den_mag);
         b_ff[0]    <= in.den_mag;
         rem_ff[0]  <= rem0;
         q_ff[0]    <= '0;
         low_ff[0]  <= 32'(in.num_mag) << FRAC_BITS;
         for (int k = 1; k <= STEPS; k++) begin
            meta_ff[k] <= meta_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            b_ff[k]    <= b_ff[k-1];
            rem_ff[k]  <= rem_in[k];
            q_ff[k]    <= {q_ff[k-1][30:0], qbit_in[k]};
            low_ff[k]  <= {low_ff[k-1][30:0], 1'b0};
         end
         // sign and saturation
         out_meta_ff <= meta_ff[STEPS];
         if (neg_ff[STEPS]) begin
            if (ovf_ff[STEPS] || (q_ff[STEPS] > 32'h8000_0000)) begin
               t_ff <= 32'sh8000_0000;
            end else begin
               t_ff <= $signed(-q_ff[STEPS]);
            end
         end else begin
            if (ovf_ff[STEPS] || q_ff[STEPS][31]) begin
               t_ff <= 32'sh7FFF_FFFF;
            end else begin
               t_ff <= $signed(q_ff[STEPS]);
            end
         end
      end
   end

   assign out.valid = out_valid_ff;
   assign out.meta  = out_meta_ff;
   assign out.t     = t_ff;

endmodule

### design/rdi_hit_check.sv
module rdi_hit_check #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  rdi_pkg::cfg_type     cfg,
   input  rdi_pkg::div_out_type in,
   output logic                 out_valid,
   output logic                 out_hit,
   output logic signed [31:0]   out_distance
);

   localparam longint T_MIN = ((64'd1 << FRAC_BITS) + 64'd999) / 64'd1000;
   localparam int     P_W   = 65 - FRAC_BITS;

   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic               x1_ff, x2_ff, x3_ff, x4_ff;
   logic signed [31:0] t1_ff, t2_ff, t3_ff, t4_ff;
   logic signed [63:0] td_ff [3];
   logic signed [32:0] oc_ff [3];
   logic signed [P_W-1:0] p_ff [3];
   logic [30:0]        m_ff [3];
   logic [61:0]        sq_ff [3];
   logic [61:0]        r2_ff;
   logic               hit_ff;
   logic signed [31:0] dist_ff;
   logic signed [31:0] ctr [3];
   logic [P_W-1:0]     pm [3];
   logic               outside;
   logic [63:0]        sum;

   assign ctr[0] = cfg.center_x;
   assign ctr[1] = cfg.center_y;
   assign ctr[2] = cfg.center_z;

   always_comb begin
      outside = 1'b0;
      for (int i = 0; i < 3; i++) begin
         pm[i]   = p_ff[i][P_W-1] ? P_W'(-p_ff[i]) : p_ff[i];
         outside = outside || (pm[i] > P_W'(cfg.radius));
      end
   end

   assign sum = 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // hit point, distance to center, squared radius test
   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff <= in.meta.miss
                  || ((in.meta.opcode == rdi_pkg::OP_PRIMARY) && (in.t < 32'(T_MIN)));
         t1_ff <= in.t;
         for (int i = 0; i < 3; i++) begin
            td_ff[i] <= 64'(in.t) * 64'($signed(in.meta.direction[i]));
            oc_ff[i] <= 33'($signed(in.meta.origin[i])) - 33'(ctr[i]);
         end
         x2_ff <= x1_ff;
         t2_ff <= t1_ff;
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= P_W'(td_ff[i] >>> FRAC_BITS) + P_W'(oc_ff[i]);
         end
         x3_ff <= x2_ff || outside;
         t3_ff <= t2_ff;
         for (int i = 0; i < 3; i++) begin
            m_ff[i] <= pm[i][30:0];
         end
         x4_ff <= x3_ff;
         t4_ff <= t3_ff;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= 62'(m_ff[i]) * 62'(m_ff[i]);
         end
         r2_ff   <= 62'(cfg.radius) * 62'(cfg.radius);
         hit_ff  <= !x4_ff && (sum <= 64'(r2_ff));
         dist_ff <= (!x4_ff && (sum <= 64'(r2_ff))) ? t4_ff : '0;
      end
   end

   assign out_valid    = v5_ff;
   assign out_hit      = hit_ff;
   assign out_distance = dist_ff;

endmodule

### design/ray_disk_intersection_unit.sv
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | opcode, origin xyz, direction xyz
// rsp     | out       | rsp_valid/rsp_stall | hit, hit_distance
// csr     | in        | csr_write_enable   | csr_index, csr_wdata
//
// one ray enters per cycle unless req_stall is high. four front stages for the
// plane dot products, a 34 stage divider (setup, one quotient bit per stage,
// saturation) and five stages for the hit point and radius test.
// synchronous reset clears the valid bits and sets the disk register defaults.
// a stalled result freezes the whole pipeline and req_stall follows it.
module ray_disk_intersection_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_direction_x,
   input  logic signed [31:0] req_direction_y,
   input  logic signed [31:0] req_direction_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_hit_distance,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   rdi_pkg::cfg_type     cfg_ff;
   rdi_pkg::div_in_type  front_out;
   rdi_pkg::div_out_type div_out;
   logic                 adv;
   logic [2:0][31:0]     origin;
   logic [2:0][31:0]     direction;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   assign origin    = {req_origin_z, req_origin_y, req_origin_x};
   assign direction = {req_direction_z, req_direction_y, req_direction_x};

   // disk registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x     <= '0;
         cfg_ff.center_y     <= '0;
         cfg_ff.center_z     <= '0;
         cfg_ff.normal_x     <= '0;
         cfg_ff.normal_y     <= 16'sd16384;
         cfg_ff.normal_z     <= '0;
         cfg_ff.radius       <= 31'd65536;
         cfg_ff.casts_shadow <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rdi_pkg::CSR_CENTER_X:     cfg_ff.center_x     <= csr_wdata;
            rdi_pkg::CSR_CENTER_Y:     cfg_ff.center_y     <= csr_wdata;
            rdi_pkg::CSR_CENTER_Z:     cfg_ff.center_z     <= csr_wdata;
            rdi_pkg::CSR_NORMAL_X:     cfg_ff.normal_x     <= csr_wdata[15:0];
            rdi_pkg::CSR_NORMAL_Y:     cfg_ff.normal_y     <= csr_wdata[15:0];
            rdi_pkg::CSR_NORMAL_Z:     cfg_ff.normal_z     <= csr_wdata[15:0];
            rdi_pkg::CSR_RADIUS:       cfg_ff.radius       <= csr_wdata[30:0];
            rdi_pkg::CSR_CASTS_SHADOW: cfg_ff.casts_shadow <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   rdi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .cfg          (cfg_ff),
      .in_valid     (req_valid),
      .in_opcode    (req_opcode),
      .in_origin    (origin),
      .in_direction (direction),
      .out          (front_out)
   );

   rdi_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .in    (front_out),
      .out   (div_out)
   );

   rdi_hit_check #(.FRAC_BITS(FRAC_BITS)) u_hit_check (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .cfg          (cfg_ff),
      .in           (div_out),
      .out_valid    (rsp_valid),
      .out_hit      (rsp_hit),
      .out_distance (rsp_hit_distance)
   );

endmodule
